/* src/set_assoc_cache_model_defines.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the set-associative cache
// Shared property wrappers, clocked on the rising edge and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef SET_ASSOC_CACHE_MODEL_DEFINES_SVH
`define SET_ASSOC_CACHE_MODEL_DEFINES_SVH

// Consequent checked in the same cycle as the antecedent
`define SACM_ASSERT_NOW(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent checked in the cycle after the antecedent
`define SACM_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* src/sacm_pkg.sv */
// ----------------------------------------------------------------------------
// sacm_pkg
// Request and response types, register codes and helpers for the cache.
// ----------------------------------------------------------------------------
`default_nettype none

package sacm_pkg;

   localparam int ADDR_W    = 48;
   localparam int STAMP_W   = 32;
   localparam int CNT_W     = 32;
   localparam int CFG_W     = 4;
   localparam int CSR_IDX_W = 2;
   localparam int SB_W      = 5;
   localparam int SHIFT_W   = 6;
   localparam int OUT_WAY_W = 3;

   localparam logic POLICY_LRU = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SET_BITS   = 2'd0,
      CSR_BLOCK_BITS = 2'd1,
      CSR_WAYS       = 2'd2,
      CSR_POLICY     = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic              func;
      logic [ADDR_W-1:0] address;
   } req_type;

   typedef struct packed {
      logic                 hit;
      logic                 mem_read;
      logic                 mem_write;
      logic [OUT_WAY_W-1:0] way;
      logic [CNT_W-1:0]     hit_total;
      logic [CNT_W-1:0]     read_total;
      logic [CNT_W-1:0]     write_total;
   } rsp_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == '1) ? v : v + CNT_W'(1);
   endfunction

endpackage

`default_nettype wire

/* src/sacm_store.sv */
// ----------------------------------------------------------------------------
// sacm_store
// Single-port-write, single-port-read RAM with a registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module sacm_store #(
   parameter int DEPTH = 1024,
   parameter int WIDTH = 904,
   localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr,
   output      logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/sacm_select.sv */
// ----------------------------------------------------------------------------
// sacm_select
// Way selection for one set: tag match, first free way, oldest-stamp victim.
// ----------------------------------------------------------------------------
`default_nettype none

module sacm_select
   import sacm_pkg::*;
#(
   parameter int MAX_WAYS   = 8,
   parameter int TAG_W      = 48,
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1),
   localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1
) (
   input  wire logic [MAX_WAYS-1:0]              valid,
   input  wire logic [MAX_WAYS-1:0][TAG_W-1:0]   tags,
   input  wire logic [MAX_WAYS-1:0][STAMP_W-1:0] fill_stamps,
   input  wire logic [MAX_WAYS-1:0][STAMP_W-1:0] use_stamps,
   input  wire logic [TAG_W-1:0]                 key_tag,
   input  wire logic [WCNT_W-1:0]                ways_eff,
   input  wire logic                             lru,
   output      logic                             hit,
   output      logic [WAY_IDX_W-1:0]             way
);

   localparam int LEAVES = 1 << WAY_IDX_W;
   localparam int NODES  = 2 * LEAVES - 1;

   logic [MAX_WAYS-1:0]  in_use;
   logic [MAX_WAYS-1:0]  match;
   logic [MAX_WAYS-1:0]  free;
   logic [WAY_IDX_W-1:0] hit_way;
   logic [WAY_IDX_W-1:0] free_way;

   logic [STAMP_W-1:0]   nd_stamp [NODES];
   logic [WAY_IDX_W-1:0] nd_idx   [NODES];
   logic                 nd_pres  [NODES];

   for (genvar w = 0; w < MAX_WAYS; w++) begin : g_way
      assign in_use[w] = (WCNT_W'(w) < ways_eff);
      assign match[w]  = valid[w] && in_use[w] && (tags[w] == key_tag);
      assign free[w]   = !valid[w] && in_use[w];
   end

   // lowest-numbered way wins
   always_comb begin
      hit_way  = '0;
      free_way = '0;
      for (int w = MAX_WAYS - 1; w >= 0; w--) begin
         if (match[w]) begin
            hit_way = WAY_IDX_W'(w);
         end
         if (free[w]) begin
            free_way = WAY_IDX_W'(w);
         end
      end
   end

   // Leaves of the victim tree; padding leaves never win
   for (genvar i = 0; i < LEAVES; i++) begin : g_leaf
      if (i < MAX_WAYS) begin : g_real
         assign nd_pres[LEAVES-1+i]  = in_use[i];
         assign nd_stamp[LEAVES-1+i] = lru ? use_stamps[i] : fill_stamps[i];
      end else begin : g_pad
         assign nd_pres[LEAVES-1+i]  = 1'b0;
         assign nd_stamp[LEAVES-1+i] = '0;
      end
      assign nd_idx[LEAVES-1+i] = WAY_IDX_W'(i);
   end

   // Keep the left child on equal stamps so the lower way wins ties
   for (genvar n = 0; n < LEAVES - 1; n++) begin : g_node
      logic take_left;
      assign take_left = nd_pres[2*n+1] &&
                         (!nd_pres[2*n+2] || (nd_stamp[2*n+1] <= nd_stamp[2*n+2]));
      assign nd_pres[n]  = nd_pres[2*n+1] || nd_pres[2*n+2];
      assign nd_stamp[n] = take_left ? nd_stamp[2*n+1] : nd_stamp[2*n+2];
      assign nd_idx[n]   = take_left ? nd_idx[2*n+1] : nd_idx[2*n+2];
   end

   assign hit = |match;
   assign way = (|match) ? hit_way : ((|free) ? free_way : nd_idx[0]);

endmodule

`default_nettype wire

/* src/set_assoc_cache_model.sv */
// ----------------------------------------------------------------------------
// set_assoc_cache_model
// Set-associative cache tracker with FIFO or LRU replacement and hit, read
// and write totals.
//
//   channel  ports                              direction  handshake
//   request  start, busy, req_data              in         start & !busy
//   result   rsp_strobe, rsp_data               out        strobe, one cycle
//   config   csr_valid, csr_ready, csr_index,   in         valid & ready
//            csr_wdata
//
// A request first does the registered read of its set row from the tag RAM,
// then tag compare, victim pick and row write-back.
// The result strobes in the cycle after the write-back; the next request may
// be taken in that same cycle.
// After reset a clearing pass over all MAX_SETS rows zeroes the valid bits; busy
// stays high throughout, configuration writes are taken as usual.
// Results cannot be stalled.
// ----------------------------------------------------------------------------
`default_nettype none
`include "set_assoc_cache_model_defines.svh"

module set_assoc_cache_model
   import sacm_pkg::*;
#(
   parameter int MAX_SETS  = 1024,
   parameter int MAX_WAYS  = 8,
   parameter int ADDR_BITS = 48
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   output      logic                 busy,
   input  wire req_type              req_data,
   output      logic                 rsp_strobe,
   output      rsp_type              rsp_data,
   input  wire logic                 csr_valid,
   output      logic                 csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_wdata
);

   localparam int SET_LOG   = $clog2(MAX_SETS + 1) - 1;
   localparam int SET_IDX_W = (MAX_SETS > 1) ? $clog2(MAX_SETS) : 1;
   localparam int WAY_IDX_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
   localparam int WCNT_W    = $clog2(MAX_WAYS + 1);
   localparam int TAG_W     = (ADDR_BITS < ADDR_W) ? ADDR_BITS : ADDR_W;
   localparam int TAG_LO    = MAX_WAYS;
   localparam int FILL_LO   = TAG_LO + MAX_WAYS * TAG_W;
   localparam int USE_LO    = FILL_LO + MAX_WAYS * STAMP_W;
   localparam int ROW_W     = USE_LO + MAX_WAYS * STAMP_W;

   localparam logic [ADDR_W-1:0] ADDR_MASK =
      (TAG_W >= ADDR_W) ? {ADDR_W{1'b1}} : ((ADDR_W'(1) << TAG_W) - ADDR_W'(1));
   localparam logic [SET_IDX_W-1:0] LAST_SET = SET_IDX_W'(MAX_SETS - 1);

   typedef enum logic [1:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOOK
   } state_type;

   // configuration registers
   logic [CFG_W-1:0] set_bits_ff;
   logic [CFG_W-1:0] block_bits_ff;
   logic [CFG_W-1:0] ways_ff;
   logic             policy_ff;

   // control and running state
   state_type            state_ff,   state_in;
   logic [SET_IDX_W-1:0] clr_ff,     clr_in;
   logic [SET_IDX_W-1:0] set_ff,     set_in;
   logic [TAG_W-1:0]     tag_ff,     tag_in;
   logic                 func_ff,    func_in;
   logic [STAMP_W-1:0]   aclk_ff,    aclk_in;
   logic [CNT_W-1:0]     hit_cnt_ff, hit_cnt_in;
   logic [CNT_W-1:0]     rd_cnt_ff,  rd_cnt_in;
   logic [CNT_W-1:0]     wr_cnt_ff,  wr_cnt_in;
   logic                 rsp_strobe_ff, rsp_strobe_in;
   rsp_type              rsp_ff,     rsp_in;

   // request decode
   logic                 accept;
   logic [ADDR_W-1:0]    addr_m;
   logic [ADDR_W-1:0]    addr_sh;
   logic [ADDR_W-1:0]    tag_sh;
   logic [SB_W-1:0]      sb_eff;
   logic [SHIFT_W-1:0]   shift_amt;
   logic [SET_IDX_W-1:0] key_set;
   logic [TAG_W-1:0]     key_tag;
   logic [7:0]           ways8;
   logic [7:0]           ways_cl;
   logic [WCNT_W-1:0]    ways_eff;

   // set row, read and written
   logic [ROW_W-1:0]                   rd_row;
   logic [MAX_WAYS-1:0]                rd_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0]     rd_tags;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   rd_fill;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   rd_use;
   logic [MAX_WAYS-1:0]                wr_valid;
   logic [MAX_WAYS-1:0][TAG_W-1:0]     wr_tags;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   wr_fill;
   logic [MAX_WAYS-1:0][STAMP_W-1:0]   wr_use;
   logic                               mem_we;
   logic [SET_IDX_W-1:0]               mem_waddr;

   logic                 sel_hit;
   logic [WAY_IDX_W-1:0] sel_way;
   logic [WAY_IDX_W+2:0] way_ext;

   assign busy      = reset || (state_ff != ST_IDLE);
   assign csr_ready = !reset;
   assign accept    = start && !busy;

   // ------------------------------------------------------------------
   // Configuration
   // ------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         set_bits_ff   <= CFG_W'(0);
         block_bits_ff <= CFG_W'(6);
         ways_ff       <= CFG_W'(1);
         policy_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_SET_BITS:   set_bits_ff   <= csr_wdata;
            CSR_BLOCK_BITS: block_bits_ff <= csr_wdata;
            CSR_WAYS:       ways_ff       <= csr_wdata;
            CSR_POLICY:     policy_ff     <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------
   // Address split
   // ------------------------------------------------------------------
   always_comb begin
      sb_eff    = ({1'b0, set_bits_ff} > SB_W'(SET_LOG)) ? SB_W'(SET_LOG)
                                                          : {1'b0, set_bits_ff};
      addr_m    = req_data.address & ADDR_MASK;
      addr_sh   = addr_m >> block_bits_ff;
      key_set   = addr_sh[SET_IDX_W-1:0] & ~({SET_IDX_W{1'b1}} << sb_eff);
      shift_amt = SHIFT_W'(block_bits_ff) + SHIFT_W'(sb_eff);
      tag_sh    = addr_m >> shift_amt;
      key_tag   = tag_sh[TAG_W-1:0];
      ways8     = {4'b0000, ways_ff};
      ways_cl   = (ways8 == 8'd0) ? 8'd1 :
                  ((ways8 > 8'(MAX_WAYS)) ? 8'(MAX_WAYS) : ways8);
      ways_eff  = ways_cl[WCNT_W-1:0];
   end

   // ------------------------------------------------------------------
   // Tag RAM: one row per set, every way of the set side by side
   // ------------------------------------------------------------------
   sacm_store #(
      .DEPTH (MAX_SETS),
      .WIDTH (ROW_W)
   ) u_store (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data ({wr_use, wr_fill, wr_tags, wr_valid}),
      .rd_en   (accept),
      .rd_addr (key_set),
      .rd_data (rd_row)
   );

   assign rd_valid = rd_row[MAX_WAYS-1:0];
   assign rd_tags  = rd_row[TAG_LO +: MAX_WAYS * TAG_W];
   assign rd_fill  = rd_row[FILL_LO +: MAX_WAYS * STAMP_W];
   assign rd_use   = rd_row[USE_LO +: MAX_WAYS * STAMP_W];

   sacm_select #(
      .MAX_WAYS (MAX_WAYS),
      .TAG_W    (TAG_W)
   ) u_select (
      .valid       (rd_valid),
      .tags        (rd_tags),
      .fill_stamps (rd_fill),
      .use_stamps  (rd_use),
      .key_tag     (tag_ff),
      .ways_eff    (ways_eff),
      .lru         (policy_ff == POLICY_LRU),
      .hit         (sel_hit),
      .way         (sel_way)
   );

   assign way_ext = {3'b000, sel_way};

   // ------------------------------------------------------------------
   // Sequencer
   // ------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      clr_in        = clr_ff;
      set_in        = set_ff;
      tag_in        = tag_ff;
      func_in       = func_ff;
      aclk_in       = aclk_ff;
      hit_cnt_in    = hit_cnt_ff;
      rd_cnt_in     = rd_cnt_ff;
      wr_cnt_in     = wr_cnt_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_waddr     = set_ff;
      wr_valid      = rd_valid;
      wr_tags       = rd_tags;
      wr_fill       = rd_fill;
      wr_use        = rd_use;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            wr_valid  = '0;
            wr_tags   = '0;
            wr_fill   = '0;
            wr_use    = '0;
            if (clr_ff == LAST_SET) begin
               state_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + SET_IDX_W'(1);
            end
         end
         ST_IDLE: begin
            if (start) begin
               set_in   = key_set;
               tag_in   = key_tag;
               func_in  = req_data.func;
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            // every request either hits or fills, so the clock always advances
            aclk_in           = aclk_ff + STAMP_W'(1);
            mem_we            = 1'b1;
            wr_valid[sel_way] = 1'b1;
            wr_tags[sel_way]  = tag_ff;
            wr_use[sel_way]   = aclk_in;
            if (sel_hit) begin
               hit_cnt_in = sat_inc(hit_cnt_ff);
            end else begin
               rd_cnt_in        = sat_inc(rd_cnt_ff);
               wr_fill[sel_way] = aclk_in;
            end
            if (func_ff) begin
               wr_cnt_in = sat_inc(wr_cnt_ff);
            end
            rsp_strobe_in      = 1'b1;
            rsp_in.hit         = sel_hit;
            rsp_in.mem_read    = !sel_hit;
            rsp_in.mem_write   = func_ff;
            rsp_in.way         = way_ext[OUT_WAY_W-1:0];
            rsp_in.hit_total   = hit_cnt_in;
            rsp_in.read_total  = rd_cnt_in;
            rsp_in.write_total = wr_cnt_in;
            state_in           = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         clr_ff        <= '0;
         aclk_ff       <= '0;
         hit_cnt_ff    <= '0;
         rd_cnt_ff     <= '0;
         wr_cnt_ff     <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         clr_ff        <= clr_in;
         aclk_ff       <= aclk_in;
         hit_cnt_ff    <= hit_cnt_in;
         rd_cnt_ff     <= rd_cnt_in;
         wr_cnt_ff     <= wr_cnt_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
      set_ff  <= set_in;
      tag_ff  <= tag_in;
      func_ff <= func_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_ff;

   // ------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------
   `SACM_ASSERT_NEXT(a_look_gives_rsp, clock, reset, state_ff == ST_LOOK, rsp_strobe, "lookup without result")
   `SACM_ASSERT_NOW(a_rsp_spaced, clock, reset, rsp_strobe, !$past(rsp_strobe), "results back to back")
   `SACM_ASSERT_NOW(a_way_marked_valid, clock, reset, state_ff == ST_LOOK, wr_valid[sel_way], "chosen way left invalid")

endmodule

`default_nettype wire
